// ----- hw/rtl/glzw_pkg.sv -----
// Shared types, constants and helpers of the GIF LZW encoder.
package glzw_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned CS_W    = 4;
    localparam int unsigned EPOCH_W = 8;

    localparam logic [CS_W-1:0] CS_DEFAULT = 4'd8;
    localparam logic [CS_W-1:0] CS_MIN     = 4'd1;
    localparam logic [CS_W-1:0] CS_MAX     = 4'd8;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic             first;
        logic [CS_W-1:0]  cs;
    } t_item;

    function automatic logic [CS_W-1:0] limit_cs(input logic [CS_W-1:0] v);
        logic [CS_W-1:0] r;
        if (v < CS_MIN) begin
            r = CS_MIN;
        end else if (v > CS_MAX) begin
            r = CS_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/glzw_if.sv -----
// Handshake interfaces for the pixel input and the byte output channels.
interface glzw_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       last;

    modport source (output valid, output pixel, output last, input ready);
    modport sink (input valid, input pixel, input last, output ready);
endinterface

interface glzw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_res;

    modport source (output valid, output data_byte, output last_res, input ready);
    modport sink (input valid, input data_byte, input last_res, output ready);
endinterface

// ----- hw/rtl/glzw_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module glzw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/glzw_front.sv -----
// Front end: accepts pixels, latches the code size per image and masks pixels.
module glzw_front
    import glzw_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [CS_W-1:0] i_code_size,
    glzw_pix_if.sink        i_pix,
    input  logic            i_full,
    output logic            o_push,
    output t_item           o_item
);

    logic            r_started;
    logic [CS_W-1:0] r_cs;
    logic [CS_W-1:0] cs_use;
    logic [8:0]      pix_mask;

    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;
    assign cs_use      = r_started ? r_cs : limit_cs(i_code_size);
    assign pix_mask    = (9'd1 << cs_use) - 9'd1;

    always_comb begin
        o_item.pixel = i_pix.pixel & pix_mask[7:0];
        o_item.last  = i_pix.last;
        o_item.first = !r_started;
        o_item.cs    = cs_use;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_cs      <= CS_DEFAULT;
        end else if (o_push) begin
            r_started <= !i_pix.last;
            r_cs      <= cs_use;
        end
    end

endmodule

// ----- hw/rtl/glzw_queue.sv -----
// Two-entry queue between the front end and the back end.
module glzw_queue
    import glzw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// ----- hw/rtl/glzw_back.sv -----
// Back end: dictionary search and update, code emission and byte packing.
module glzw_back
    import glzw_pkg::*;
#(
    parameter int unsigned HASH_SIZE     = 8192,
    parameter int unsigned MAX_CODE_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_item      i_item,
    output logic       o_pop,
    glzw_byte_if.source o_byte
);

    localparam int unsigned HB  = $clog2(HASH_SIZE);
    localparam int unsigned MCB = MAX_CODE_BITS;
    localparam int unsigned KW  = MCB + PIX_W;
    localparam int unsigned NCW = MCB + 1;
    localparam int unsigned WW  = $clog2(MCB + 1);
    localparam int unsigned BW  = MCB + 8;
    localparam int unsigned CW  = $clog2(BW + 1);
    localparam int unsigned DW  = KW + MCB + EPOCH_W;

    typedef enum logic [3:0] {
        S_WIPE, S_IDLE, S_HASH, S_CLR, S_PUTCLR, S_RD, S_CMP, S_UPD,
        S_FULLCLR, S_FINCK, S_PUTEND, S_DRAIN, S_FLUSH
    } t_state;

    t_state              r_state, n_state;
    t_state              r_ret, n_ret;
    logic [CS_W-1:0]     r_cs, n_cs;
    logic [PIX_W-1:0]    r_pix, n_pix;
    logic                r_last, n_last;
    logic [MCB-1:0]      r_prefix, n_prefix;
    logic [NCW-1:0]      r_next, n_next;
    logic [WW-1:0]       r_width, n_width;
    logic [BW-1:0]       r_buf, n_buf;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [HB-1:0]       r_hash, n_hash;
    logic [HB-1:0]       r_wipe, n_wipe;
    logic [EPOCH_W-1:0]  r_epoch, n_epoch;
    logic                r_ov, n_ov;
    logic [7:0]          r_ob, n_ob;
    logic                r_ol, n_ol;
    logic [2:0]          r_nb, n_nb;
    logic [31:0]         r_hv, n_hv;

    logic                ram_we;
    logic [HB-1:0]       ram_waddr;
    logic [DW-1:0]       ram_wdata;
    logic [DW-1:0]       ram_rdata;
    logic [KW-1:0]       rd_key;
    logic [MCB-1:0]      rd_code;
    logic [EPOCH_W-1:0]  rd_epoch;
    logic [MCB-1:0]      clear_code;
    logic [MCB-1:0]      put_code;
    logic [BW-1:0]       put_buf;
    logic [CW-1:0]       put_cnt;
    logic [31:0]         hash_val;
    logic                out_free;
    logic                byte_drop;

    glzw_ram #(.WIDTH(DW), .DEPTH(HASH_SIZE)) u_dict (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_hash),
        .o_rdata (ram_rdata)
    );

    assign rd_key     = ram_rdata[DW-1 -: KW];
    assign rd_code    = ram_rdata[MCB+EPOCH_W-1:EPOCH_W];
    assign rd_epoch   = ram_rdata[EPOCH_W-1:0];
    assign clear_code = MCB'(1) << r_cs;
    assign out_free   = !r_ov || o_byte.ready;
    assign byte_drop  = (r_nb == 3'd7);
    assign hash_val   = (32'(i_item.pixel) << 4) ^ 32'(r_prefix);

    assign o_byte.valid     = r_ov;
    assign o_byte.data_byte = r_ob;
    assign o_byte.last_res  = r_ol;

    always_comb begin
        case (r_state)
            S_PUTCLR, S_UPD: put_code = clear_code;
            S_PUTEND:        put_code = clear_code + MCB'(1);
            default:         put_code = r_prefix;
        endcase
        put_buf = r_buf | ((BW'(put_code) & ((BW'(1) << r_width) - BW'(1))) << r_cnt);
        put_cnt = r_cnt + CW'(r_width);
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_cs     = r_cs;
        n_pix    = r_pix;
        n_last   = r_last;
        n_prefix = r_prefix;
        n_next   = r_next;
        n_width  = r_width;
        n_buf    = r_buf;
        n_cnt    = r_cnt;
        n_hash   = r_hash;
        n_wipe   = r_wipe;
        n_epoch  = r_epoch;
        n_ov     = r_ov && !o_byte.ready;
        n_ob     = r_ob;
        n_ol     = r_ol;
        n_nb     = r_nb;
        n_hv     = r_hv;
        o_pop    = 1'b0;
        ram_we   = 1'b0;
        ram_waddr = r_hash;
        ram_wdata = {r_prefix, r_pix, r_next[MCB-1:0], r_epoch};
        case (r_state)
            S_WIPE: begin
                ram_we    = 1'b1;
                ram_waddr = r_wipe;
                ram_wdata = '0;
                n_wipe    = r_wipe + HB'(1);
                if (r_wipe == HB'(HASH_SIZE - 1)) begin
                    n_epoch = EPOCH_W'(1);
                    n_wipe  = '0;
                    n_state = r_ret;
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_pix  = i_item.pixel;
                    n_last = i_item.last;
                    n_nb   = '0;
                    if (i_item.first) begin
                        n_cs     = i_item.cs;
                        n_prefix = MCB'(i_item.pixel);
                        n_ret    = S_PUTCLR;
                        n_state  = S_CLR;
                    end else if (hash_val < 32'(HASH_SIZE)) begin
                        n_hash  = hash_val[HB-1:0];
                        n_state = S_RD;
                    end else begin
                        n_hv    = hash_val;
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (r_hv >= 32'(HASH_SIZE)) begin
                    n_hv = r_hv - 32'(HASH_SIZE);
                end else begin
                    n_hash  = r_hv[HB-1:0];
                    n_state = S_RD;
                end
            end
            S_CLR: begin
                n_next  = (NCW'(1) << r_cs) + NCW'(2);
                n_width = WW'(r_cs) + WW'(1);
                if (r_epoch == '1) begin
                    n_state = S_WIPE;
                end else begin
                    n_epoch = r_epoch + EPOCH_W'(1);
                    n_state = r_ret;
                end
            end
            S_PUTCLR: begin
                n_buf   = put_buf;
                n_cnt   = put_cnt;
                n_ret   = S_FINCK;
                n_state = S_DRAIN;
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (rd_epoch != r_epoch) begin
                    n_buf   = put_buf;
                    n_cnt   = put_cnt;
                    n_ret   = S_UPD;
                    n_state = S_DRAIN;
                end else if (rd_key == {r_prefix, r_pix}) begin
                    n_prefix = rd_code;
                    n_state  = S_FINCK;
                end else begin
                    n_hash  = (r_hash == HB'(HASH_SIZE - 1)) ? '0 : r_hash + HB'(1);
                    n_state = S_RD;
                end
            end
            S_UPD: begin
                if (!r_next[MCB]) begin
                    ram_we   = 1'b1;
                    n_next   = r_next + NCW'(1);
                    if ((r_next >> r_width) != '0) begin
                        n_width = r_width + WW'(1);
                    end
                    n_prefix = MCB'(r_pix);
                    n_state  = S_FINCK;
                end else begin
                    n_buf   = put_buf;
                    n_cnt   = put_cnt;
                    n_ret   = S_FULLCLR;
                    n_state = S_DRAIN;
                end
            end
            S_FULLCLR: begin
                n_prefix = MCB'(r_pix);
                n_ret    = S_FINCK;
                n_state  = S_CLR;
            end
            S_FINCK: begin
                if (r_last) begin
                    n_buf   = put_buf;
                    n_cnt   = put_cnt;
                    n_ret   = S_PUTEND;
                    n_state = S_DRAIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PUTEND: begin
                n_buf   = put_buf;
                n_cnt   = put_cnt;
                n_ret   = S_FLUSH;
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (r_cnt > CW'(8)) begin
                    if (byte_drop) begin
                        n_buf = r_buf >> 8;
                        n_cnt = r_cnt - CW'(8);
                    end else if (out_free) begin
                        n_ov  = 1'b1;
                        n_ob  = r_buf[7:0];
                        n_ol  = 1'b0;
                        n_buf = r_buf >> 8;
                        n_cnt = r_cnt - CW'(8);
                        n_nb  = r_nb + 3'd1;
                    end
                end else begin
                    n_state = r_ret;
                end
            end
            S_FLUSH: begin
                if (byte_drop) begin
                    n_buf    = '0;
                    n_cnt    = '0;
                    n_prefix = '0;
                    n_state  = S_IDLE;
                end else if (out_free) begin
                    n_ov     = 1'b1;
                    n_ob     = r_buf[7:0];
                    n_ol     = 1'b1;
                    n_buf    = '0;
                    n_cnt    = '0;
                    n_prefix = '0;
                    n_nb     = r_nb + 3'd1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_WIPE;
            r_ret    <= S_IDLE;
            r_cs     <= CS_DEFAULT;
            r_prefix <= '0;
            r_next   <= (NCW'(1) << CS_DEFAULT) + NCW'(2);
            r_width  <= WW'(CS_DEFAULT) + WW'(1);
            r_buf    <= '0;
            r_cnt    <= '0;
            r_hash   <= '0;
            r_wipe   <= '0;
            r_epoch  <= '0;
            r_ov     <= 1'b0;
            r_nb     <= '0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_cs     <= n_cs;
            r_prefix <= n_prefix;
            r_next   <= n_next;
            r_width  <= n_width;
            r_buf    <= n_buf;
            r_cnt    <= n_cnt;
            r_hash   <= n_hash;
            r_wipe   <= n_wipe;
            r_epoch  <= n_epoch;
            r_ov     <= n_ov;
            r_nb     <= n_nb;
        end
        r_pix  <= n_pix;
        r_last <= n_last;
        r_ob   <= n_ob;
        r_ol   <= n_ol;
        r_hv   <= n_hv;
    end

endmodule

// ----- hw/rtl/gif_lzw_encoder.sv -----
// Top level of the GIF LZW encoder: pixels in, packed code stream bytes out.
//
// Channel   Direction  Word                     Handshake
// i_pix     in         pixel[7:0], last         valid/ready
// o_byte    out        data_byte[7:0], last_res valid/ready
// i_cfg     in         code_size[3:0]           write enable only
//
// A pixel is looked up in the hash table by linear probing; a miss emits the prefix
// code and writes the new entry, and a hash beyond the table is first reduced modulo
// the table size. The first pixel of an image and a full table send a clear code, and
// the final pixel adds the end code and the flush byte.
// After reset the dictionary tags are wiped, and again each time the 8-bit generation
// count wraps; pixels queue up meanwhile.
// A stalled output holds the back end while the front end keeps filling its queue.
module gif_lzw_encoder
    import glzw_pkg::*;
#(
    parameter int unsigned HASH_SIZE     = 8192,
    parameter int unsigned MAX_CODE_BITS = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [CS_W-1:0] i_cfg_data,
    glzw_pix_if.sink        i_pix,
    glzw_byte_if.source     o_byte
);

    logic [CS_W-1:0] r_code_size;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    t_item           front_item;
    t_item           head_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_size <= CS_DEFAULT;
        end else if (i_cfg_we) begin
            r_code_size <= i_cfg_data;
        end
    end

    glzw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_code_size (r_code_size),
        .i_pix       (i_pix),
        .i_full      (full),
        .o_push      (push),
        .o_item      (front_item)
    );

    glzw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (head_item)
    );

    glzw_back #(
        .HASH_SIZE     (HASH_SIZE),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_item  (head_item),
        .o_pop   (pop),
        .o_byte  (o_byte)
    );

endmodule

// ----- hw/rtl/glzw_checker.sv -----
// Port-level checks of the GIF LZW encoder and their binding to the top level.
module glzw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last))
        else $error("output word changed while stalled");

    a_single_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last |=> !(i_out_valid && i_out_last))
        else $error("two final words in a row");

endmodule

bind gif_lzw_encoder glzw_checker u_glzw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_byte.valid),
    .i_out_ready (o_byte.ready),
    .i_out_byte  (o_byte.data_byte),
    .i_out_last  (o_byte.last_res)
);
